### src/rlms_pkg.sv
// Package for the LED matrix row scanner: pixel, command and result types
// shared by the front end, the scan engine and the result queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlms_pkg;

	localparam int COLS = 16;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [3:0] red;
		logic [3:0] green;
		logic [3:0] blue;
	} pix_t;

	typedef pix_t [COLS-1:0] row_t;

	typedef struct packed {
		logic       is_tick;
		logic [2:0] row;
		logic [3:0] col;
		pix_t       pix;
	} cmd_t;

	typedef struct packed {
		logic [7:0] row_drive;
		logic [1:0] channel;
		logic [7:0] high_byte;
		logic [7:0] low_byte;
		logic       blank;
	} res_t;

endpackage

`default_nettype wire

### src/rlms_front.sv
// Front end of the scanner: accepts input items, drops writes to rows that do
// not exist and queues the rest in order. Depends on rlms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlms_front
	import rlms_pkg::*;
#(
	parameter int ROWS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       req_type,
	input  wire logic [2:0] pixel_row,
	input  wire logic [3:0] pixel_col,
	input  wire logic [3:0] red_level,
	input  wire logic [3:0] green_level,
	input  wire logic [3:0] blue_level,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  wire logic       cmd_take
);

	cmd_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       accept;
	logic       keep;
	logic       enq;
	logic [5:0] row_ext;

	assign full     = (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign row_ext  = {3'b000, pixel_row};
	// A tick is always kept; a write only when its row is present.
	assign keep     = (req_type == REQ_TICK) || (row_ext < 6'(ROWS));
	assign enq      = accept && keep;

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (enq) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, cmd_take};
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wr_q] <= '{is_tick: (req_type == REQ_TICK), row: pixel_row, col: pixel_col,
				pix: '{red: red_level, green: green_level, blue: blue_level}};
		end
	end

endmodule

`default_nettype wire

### src/rlms_back.sv
// Scan engine: holds the frame store and the row, colour and slice counters,
// applies pixel writes and turns each tick into one PWM slice. Depends on rlms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlms_back
	import rlms_pkg::*;
#(
	parameter int LEVELS = 15,
	parameter int ROWS   = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_take,
	input  wire logic res_full,
	output logic      res_push,
	output res_t      res
);

	localparam int RW = $clog2(ROWS);
	localparam int SW = $clog2(LEVELS + 1);
	localparam int CW = (SW > 4) ? SW : 4;

	row_t          store_q [ROWS];
	logic [RW-1:0] row_q;
	logic [RW-1:0] row_nxt;
	logic [RW-1:0] wr_row;
	logic [5:0]    wr_ext;
	logic [7:0]    shift_q;
	logic [7:0]    shift_nxt;
	logic [1:0]    chan_q;
	logic [SW-1:0] slice_q;
	logic          row_start;
	logic          tick_go;
	logic          wr_go;
	logic          blank;
	logic [15:0]   on_bits;
	logic [15:0]   word;
	row_t          cur_row;

	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = v[7-k];
		end
		return r;
	endfunction

	function automatic logic [3:0] chan_level(input pix_t p, input logic [1:0] ch);
		logic [3:0] l;
		case (ch)
			CH_GREEN: l = p.green;
			CH_BLUE:  l = p.blue;
			default:  l = p.red;
		endcase
		return l;
	endfunction

	// Writes need no result space; ticks wait for room in the result queue.
	assign cmd_take = cmd_valid && (!cmd.is_tick || !res_full);
	assign tick_go  = cmd_take && cmd.is_tick;
	assign wr_go    = cmd_take && !cmd.is_tick;
	assign res_push = tick_go;

	assign wr_ext = {3'b000, cmd.row};
	assign wr_row = wr_ext[RW-1:0];

	assign row_start = (chan_q == CH_RED) && (slice_q == '0);
	assign row_nxt   = !row_start ? row_q :
		((row_q == RW'(ROWS - 1)) ? '0 : row_q + 1'b1);
	assign shift_nxt = row_start ? {shift_q[6:0], (row_nxt == '0)} : shift_q;

	assign cur_row = store_q[row_nxt];
	assign blank   = (slice_q == SW'(LEVELS));

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			on_bits[15-c] = CW'(chan_level(cur_row[c], chan_q)) > CW'(slice_q);
		end
	end

	assign word = blank ? 16'hFFFF : ~on_bits;

	assign res.row_drive = shift_nxt;
	assign res.channel   = chan_q;
	assign res.high_byte = word[15:8];
	assign res.low_byte  = (chan_q == CH_GREEN) ? word[7:0] : flip8(word[7:0]);
	assign res.blank     = blank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			shift_q <= 8'd0;
			chan_q  <= CH_RED;
			slice_q <= '0;
			for (int r = 0; r < ROWS; r++) begin
				store_q[r] <= '0;
			end
		end else begin
			if (tick_go) begin
				row_q   <= row_nxt;
				shift_q <= shift_nxt;
				if (blank) begin
					slice_q <= '0;
					chan_q  <= (chan_q == CH_BLUE) ? CH_RED : chan_q + 2'd1;
				end else begin
					slice_q <= slice_q + 1'b1;
				end
			end
			if (wr_go) begin
				store_q[wr_row][cmd.col] <= cmd.pix;
			end
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result pushed into a full queue");
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q == CH_RED || chan_q == CH_GREEN || chan_q == CH_BLUE)
		else $error("colour counter out of range");
	a_slice_range: assert property (@(posedge clk) disable iff (!arst_n)
		slice_q <= SW'(LEVELS)) else $error("slice counter out of range");
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_go |=> $stable(row_q) && $stable(chan_q) && $stable(slice_q))
		else $error("scan moved without a tick");
`endif

endmodule

`default_nettype wire

### src/rlms_outq.sv
// Two-entry result queue between the scan engine and the result ports.
// Depends on rlms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlms_outq
	import rlms_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	input  wire res_t res_in,
	output logic      res_full,
	output logic      empty,
	input  wire logic pop,
	output res_t      head
);

	res_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       deq;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign deq      = pop && !empty;
	assign head     = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (res_push) begin
				wr_q <= ~wr_q;
			end
			if (deq) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, deq};
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			ent_q[wr_q] <= res_in;
		end
	end

endmodule

`default_nettype wire

### src/rgb_led_matrix_pwm_scanner.sv
// Top level of the RGB LED matrix row scanner with compare-based PWM.
// Depends on rlms_pkg, rlms_front, rlms_back and rlms_outq.
//
//   Channel   Transfer when         Fields
//   input     push && !full         req_type, pixel_row, pixel_col, red/green/blue_level
//   result    pop && !empty         row_drive, colour_channel, high_byte, low_byte,
//                                   blank_slice
//
// One item is taken per clock while the front queue has room, and one slice is
// produced per clock while the result queue has room; the scan engine handles
// each item combinationally, with the frame store row read and the sixteen
// level compares. The front queue registers a tick, and the scan engine writes
// its slice into the result queue, from which it reaches the result ports.
// Reset clears the frame store, the counters and both queues at once.
// The result side can stall on its own: ticks then wait in the front queue,
// as do the pixel writes behind them, and full rises once both queues are full.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_matrix_pwm_scanner
	import rlms_pkg::*;
#(
	parameter int LEVELS = 15,
	parameter int ROWS   = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       req_type,
	input  wire logic [2:0] pixel_row,
	input  wire logic [3:0] pixel_col,
	input  wire logic [3:0] red_level,
	input  wire logic [3:0] green_level,
	input  wire logic [3:0] blue_level,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      row_drive,
	output logic [1:0]      colour_channel,
	output logic [7:0]      high_byte,
	output logic [7:0]      low_byte,
	output logic            blank_slice
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	logic res_full;
	logic res_push;
	res_t res;
	res_t head;

	// The front queue keeps writes and ticks in arrival order, so a tick
	// always sees every write that came before it.
	rlms_front #(
		.ROWS(ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	// The scan engine stores pixels and builds one slice per tick.
	rlms_back #(
		.LEVELS(LEVELS),
		.ROWS  (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// Slices wait here until the consumer takes them.
	rlms_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_push(res_push),
		.res_in  (res),
		.res_full(res_full),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign row_drive      = head.row_drive;
	assign colour_channel = head.channel;
	assign high_byte      = head.high_byte;
	assign low_byte       = head.low_byte;
	assign blank_slice    = head.blank;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for rgb_led_matrix_pwm_scanner: random pixel writes and refresh
// ticks, each slice compared with a model of the scan. Depends on rlms_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import rlms_pkg::*;

	localparam int LEVELS = 15;
	localparam int ROWS   = 8;
	localparam int RANDOM_ITEMS = 950;
	localparam int HOLD_CYCLES  = 250;

	// The scan model keeps its own frame store and counters. Each accepted tick
	// yields one expected slice, and each popped slice is checked against the oldest.
	class scan_scoreboard;
		pix_t       frame [ROWS][COLS];
		logic [2:0] row_idx;
		logic [7:0] row_shift;
		logic [1:0] channel;
		int         slice;
		res_t       pending [$];
		int         errors;
		int         seen;

		function void clear();
			foreach (frame[r, c])
				frame[r][c] = '0;
			row_idx   = '0;
			row_shift = '0;
			channel   = CH_RED;
			slice     = 0;
			pending.delete();
			errors    = 0;
			seen      = 0;
		endfunction

		function void note_input(cmd_t c);
			logic [15:0] lit;
			logic [15:0] word;
			logic [3:0]  lvl;
			res_t        exp_res;
			if (c.is_tick == REQ_WRITE) begin
				if (int'(c.row) < ROWS)
					frame[c.row][c.col] = c.pix;
				return;
			end
			// A new row starts with the red phase at slice zero.
			if (channel == CH_RED && slice == 0) begin
				row_idx   = (int'(row_idx) == ROWS - 1) ? 3'd0 : row_idx + 3'd1;
				row_shift = {row_shift[6:0], row_idx == 3'd0};
			end
			lit = '0;
			if (slice < LEVELS) begin
				for (int col = 0; col < COLS; col++) begin
					case (channel)
						CH_RED:   lvl = frame[row_idx][col].red;
						CH_GREEN: lvl = frame[row_idx][col].green;
						default:  lvl = frame[row_idx][col].blue;
					endcase
					if (int'(lvl) >= slice + 1)
						lit[15 - col] = 1'b1;
				end
			end
			word = ~lit;
			exp_res.row_drive = row_shift;
			exp_res.channel   = channel;
			exp_res.high_byte = word[15:8];
			// Red and blue are wired with the low byte mirrored.
			exp_res.low_byte  = (channel == CH_GREEN) ? word[7:0] : {<<{word[7:0]}};
			exp_res.blank     = (slice >= LEVELS);
			pending.push_back(exp_res);
			if (slice >= LEVELS) begin
				slice   = 0;
				channel = (channel == CH_BLUE) ? CH_RED : channel + 2'd1;
			end else begin
				slice++;
			end
		endfunction

		function void check_result(res_t got);
			res_t exp_res;
			seen++;
			if (pending.size() == 0) begin
				$error("slice popped with none outstanding");
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (got.row_drive !== exp_res.row_drive) begin
				$error("row_drive: expected %0h, got %0h", exp_res.row_drive, got.row_drive);
				errors++;
			end
			if (got.channel !== exp_res.channel) begin
				$error("colour_channel: expected %0d, got %0d", exp_res.channel, got.channel);
				errors++;
			end
			if (got.high_byte !== exp_res.high_byte) begin
				$error("high_byte: expected %0h, got %0h", exp_res.high_byte, got.high_byte);
				errors++;
			end
			if (got.low_byte !== exp_res.low_byte) begin
				$error("low_byte: expected %0h, got %0h", exp_res.low_byte, got.low_byte);
				errors++;
			end
			if (got.blank !== exp_res.blank) begin
				$error("blank_slice: expected %0d, got %0d", exp_res.blank, got.blank);
				errors++;
			end
		endfunction
	endclass

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic       req_type    = REQ_WRITE;
	logic [2:0] pixel_row   = '0;
	logic [3:0] pixel_col   = '0;
	logic [3:0] red_level   = '0;
	logic [3:0] green_level = '0;
	logic [3:0] blue_level  = '0;
	logic       pop         = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] row_drive;
	logic [1:0] colour_channel;
	logic [7:0] high_byte;
	logic [7:0] low_byte;
	logic       blank_slice;

	scan_scoreboard sb = new;

	rgb_led_matrix_pwm_scanner #(
		.LEVELS(LEVELS),
		.ROWS  (ROWS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.pixel_row     (pixel_row),
		.pixel_col     (pixel_col),
		.red_level     (red_level),
		.green_level   (green_level),
		.blue_level    (blue_level),
		.empty         (empty),
		.pop           (pop),
		.row_drive     (row_drive),
		.colour_channel(colour_channel),
		.high_byte     (high_byte),
		.low_byte      (low_byte),
		.blank_slice   (blank_slice)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offers one item from the falling edge on and returns after the rising edge
	// at which it was taken. Push stays high if the caller sends again at once.
	task automatic send_cmd(input cmd_t c);
		@(negedge clk);
		push        <= 1'b1;
		req_type    <= c.is_tick;
		pixel_row   <= c.row;
		pixel_col   <= c.col;
		red_level   <= c.pix.red;
		green_level <= c.pix.green;
		blue_level  <= c.pix.blue;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_input(c);
	endtask

	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	function automatic cmd_t pixel_write(input int r, input int c, input int rl,
	                                     input int gl, input int bl);
		cmd_t w;
		w.is_tick   = REQ_WRITE;
		w.row       = 3'(r);
		w.col       = 4'(c);
		w.pix.red   = 4'(rl);
		w.pix.green = 4'(gl);
		w.pix.blue  = 4'(bl);
		return w;
	endfunction

	// Mostly ticks so that the scan wraps the frame about twice, with writes
	// landing in random rows and columns.
	function automatic cmd_t random_cmd();
		cmd_t c;
		c.is_tick = ($urandom_range(0, 99) < 78) ? REQ_TICK : REQ_WRITE;
		c.row     = 3'($urandom_range(0, 7));
		c.col     = 4'($urandom_range(0, 15));
		c.pix     = 12'($urandom);
		return c;
	endfunction

	// Every slice taken by the receiver goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result('{row_drive, colour_channel, high_byte, low_byte, blank_slice});
	end

	// The receiver cycles through three pop patterns, and once, after a hundred
	// slices, holds off long enough for both queues to fill and full to rise.
	initial begin
		int cyc;
		int hold_left;
		bit hold_done;
		cyc       = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!hold_done && sb.seen >= 100) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case ((cyc / 64) % 3)
					0:       pop <= 1'b1;
					1:       pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		cmd_t tick;
		int   sent;
		int   burst;
		int   waited;
		sb.clear();
		tick         = '0;
		tick.is_tick = REQ_TICK;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The first tick scans row one, so the directed pixels sit there, with
		// full-scale and dark corners elsewhere in the frame.
		send_cmd(pixel_write(1, 0, 15, 0, 15));
		send_cmd(pixel_write(1, 15, 1, 15, 0));
		send_cmd(pixel_write(1, 7, 8, 7, 15));
		send_cmd(pixel_write(1, 8, 14, 1, 9));
		send_cmd(pixel_write(0, 0, 15, 15, 15));
		send_cmd(pixel_write(7, 15, 15, 15, 15));
		repeat (8)
			send_cmd(tick);
		// A write in the middle of the red phase must not disturb the slice count.
		send_cmd(pixel_write(1, 3, 15, 15, 15));
		repeat (9)
			send_cmd(tick);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			repeat (burst)
				send_cmd(random_cmd());
			sent += burst;
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 8));
		end
		idle_sender(1);

		waited = 0;
		while (sb.pending.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending.size() > 0) begin
			$error("%0d slices never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
